FILE: hdl/twc_pkg.sv
// ----------------------------------------------------------------------------
// twc_pkg
// Types and codes shared by the windowed ping-pong capture block.
// ----------------------------------------------------------------------------
package twc_pkg;

   localparam int CSR_AW = 5;

   typedef enum logic [1:0] {
      KIND_PACKET   = 2'd0,
      KIND_RETRIEVE = 2'd1,
      KIND_START    = 2'd2,
      KIND_STOP     = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      POLICY_DISCARD = 2'd0,
      POLICY_HOLD    = 2'd1,
      POLICY_BLOCK   = 2'd2
   } policy_type;

   typedef enum logic [2:0] {
      REG_ARMED            = 3'd0,
      REG_TRIGGER_DELAY    = 3'd1,
      REG_WINDOW_LENGTH    = 3'd2,
      REG_RETRIGGER_ENABLE = 3'd3,
      REG_RETRIGGER_PERIOD = 3'd4,
      REG_END_POLICY       = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic        armed;
      logic [31:0] trigger_delay;
      logic [10:0] window_length;
      logic        retrigger_enable;
      logic [31:0] retrigger_period;
      logic [1:0]  end_policy;
   } cfg_type;

   typedef struct packed {
      logic        hit;
      logic [31:0] index;
      logic [10:0] avail;
      logic        exists;
   } stat_type;

endpackage

FILE: hdl/twc_req_if.sv
// ----------------------------------------------------------------------------
// twc_req_if
// Input channel of the capture block: one item kind and one packet word.
// ----------------------------------------------------------------------------
interface twc_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [63:0] packet_data;

   modport source (output valid, output kind, output packet_data, input ready);
   modport sink (input valid, input kind, input packet_data, output ready);
endinterface

FILE: hdl/twc_rsp_if.sv
// ----------------------------------------------------------------------------
// twc_rsp_if
// Result channel of the capture block: one result per input item.
// ----------------------------------------------------------------------------
interface twc_rsp_if;
   logic        valid;
   logic        ready;
   logic        read_valid;
   logic [63:0] read_data;
   logic [31:0] read_index;
   logic [10:0] retrievable;
   logic        capture_exists;

   modport source (output valid, output read_valid, output read_data, output read_index,
                   output retrievable, output capture_exists, input ready);
   modport sink (input valid, input read_valid, input read_data, input read_index,
                 input retrievable, input capture_exists, output ready);
endinterface

FILE: hdl/twc_csr.sv
// ----------------------------------------------------------------------------
// twc_csr
// Configuration registers behind an APB-style port.
// ----------------------------------------------------------------------------
module twc_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [twc_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [31:0]                 csr_pwdata,
   output logic [31:0]                 csr_prdata,
   output logic                        csr_pready,
   output twc_pkg::cfg_type            cfg
);
   import twc_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   logic          wr_stb;
   reg_index_type reg_sel;

   assign csr_pready = 1'b1;
   assign wr_stb     = csr_psel && csr_penable && csr_pwrite;
   assign reg_sel    = reg_index_type'(csr_paddr[CSR_AW-1:2]);
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_stb) begin
         unique case (reg_sel)
            REG_ARMED:            cfg_in.armed            = csr_pwdata[0];
            REG_TRIGGER_DELAY:    cfg_in.trigger_delay    = csr_pwdata;
            REG_WINDOW_LENGTH:    cfg_in.window_length    = csr_pwdata[10:0];
            REG_RETRIGGER_ENABLE: cfg_in.retrigger_enable = csr_pwdata[0];
            REG_RETRIGGER_PERIOD: cfg_in.retrigger_period = csr_pwdata;
            REG_END_POLICY:       cfg_in.end_policy       = csr_pwdata[1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_ARMED:            csr_prdata = {31'd0, cfg_ff.armed};
         REG_TRIGGER_DELAY:    csr_prdata = cfg_ff.trigger_delay;
         REG_WINDOW_LENGTH:    csr_prdata = {21'd0, cfg_ff.window_length};
         REG_RETRIGGER_ENABLE: csr_prdata = {31'd0, cfg_ff.retrigger_enable};
         REG_RETRIGGER_PERIOD: csr_prdata = cfg_ff.retrigger_period;
         REG_END_POLICY:       csr_prdata = {30'd0, cfg_ff.end_policy};
         default:              csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.armed            <= 1'b0;
         cfg_ff.trigger_delay    <= 32'd0;
         cfg_ff.window_length    <= 11'd1;
         cfg_ff.retrigger_enable <= 1'b0;
         cfg_ff.retrigger_period <= 32'd1;
         cfg_ff.end_policy       <= POLICY_DISCARD;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: hdl/twc_store.sv
// ----------------------------------------------------------------------------
// twc_store
// Two capture buffers in one synchronous memory with a registered read port.
// ----------------------------------------------------------------------------
module twc_store #(
   parameter int BUFFER_DEPTH = 1024,
   parameter int WORD_BITS    = 64,
   parameter int AW           = 10
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic                 wr_buf,
   input  logic [AW-1:0]        wr_addr,
   input  logic [WORD_BITS-1:0] wr_data,
   input  logic                 rd_en,
   input  logic                 rd_buf,
   input  logic [AW-1:0]        rd_addr,
   output logic [WORD_BITS-1:0] rd_data
);

   logic [WORD_BITS-1:0] mem_ff [2][BUFFER_DEPTH];
   logic [WORD_BITS-1:0] rd_data_ff;

   assign rd_data = rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_buf][wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_buf][rd_addr];
      end
   end

endmodule

FILE: hdl/twc_ctrl.sv
// ----------------------------------------------------------------------------
// twc_ctrl
// Capture sequencing: packet counting, window phase, buffer selection and
// the read and fill counters of both buffers.
// ----------------------------------------------------------------------------
module twc_ctrl #(
   parameter int BUFFER_DEPTH = 1024,
   parameter int WORD_BITS    = 64,
   parameter int AW           = 10,
   parameter int CW           = 11
) (
   input  logic                 clock,
   input  logic                 reset,
   input  twc_pkg::cfg_type     cfg,
   input  logic                 accept,
   input  logic [1:0]           kind,
   input  logic [63:0]          packet_data,
   output logic                 wr_en,
   output logic                 wr_buf,
   output logic [AW-1:0]        wr_addr,
   output logic [WORD_BITS-1:0] wr_data,
   output logic                 rd_en,
   output logic                 rd_buf,
   output logic [AW-1:0]        rd_addr,
   output twc_pkg::stat_type    stat
);
   import twc_pkg::*;

   localparam int LXW = (CW > 11) ? CW : 11;

   logic [31:0]   lat_delay_ff, lat_delay_in;
   logic [CW-1:0] lat_len_ff, lat_len_in;
   logic          lat_retrig_ff, lat_retrig_in;
   logic [31:0]   lat_period_ff, lat_period_in;
   logic [1:0]    lat_policy_ff, lat_policy_in;
   logic [31:0]   pc_ff, pc_in;
   logic [31:0]   ph_ff, ph_in;
   logic [CW-1:0] fill_ff [2];
   logic [CW-1:0] fill_in [2];
   logic [CW-1:0] rd_ff [2];
   logic [CW-1:0] rd_in [2];
   logic [31:0]   wst_ff [2];
   logic [31:0]   wst_in [2];
   logic          cur_ff, cur_in;
   logic          exists_ff, exists_in;
   logic          active_ff, active_in;
   logic          dd_ff, dd_in;

   logic [LXW-1:0] wl_ext;
   logic [CW-1:0]  len_new;
   logic           delay_wait;
   logic [31:0]    ph;
   logic [31:0]    ph_inc;
   logic [31:0]    ph_next;
   logic           in_window;
   logic           ph_zero;
   logic           swap;
   logic           wbuf;
   logic [CW-1:0]  wfill;
   logic           room;
   logic           old_none;
   logic           old_buf;
   logic           hit;
   logic [CW-1:0]  rd_inc;
   logic [CW-1:0]  avail;
   logic [LXW-1:0] avail_ext;

   assign wl_ext  = LXW'(cfg.window_length);
   assign len_new = (wl_ext > LXW'(BUFFER_DEPTH)) ? CW'(BUFFER_DEPTH) : CW'(wl_ext);

   assign delay_wait = !dd_ff && (pc_ff < lat_delay_ff);
   assign ph         = dd_ff ? ph_ff : 32'd0;
   assign ph_inc     = ph + 32'd1;
   assign in_window  = ph < 32'(lat_len_ff);
   assign ph_zero    = (ph == 32'd0);
   assign swap       = ph_zero && (fill_ff[cur_ff] != '0) && (rd_ff[cur_ff] != '0);
   assign wbuf       = cur_ff ^ swap;
   assign wfill      = ph_zero ? '0 : fill_ff[wbuf];
   assign room       = wfill < lat_len_ff;

   always_comb begin
      if (lat_retrig_ff) begin
         ph_next = (ph_inc >= lat_period_ff) ? 32'd0 : ph_inc;
      end else begin
         ph_next = in_window ? ph_inc : ph;
      end
   end

   assign old_none = (fill_ff[0] == '0) && (fill_ff[1] == '0);
   always_comb begin
      if (fill_ff[0] == '0) begin
         old_buf = 1'b1;
      end else if (fill_ff[1] == '0) begin
         old_buf = 1'b0;
      end else begin
         old_buf = (wst_ff[0] <= wst_ff[1]) ? 1'b0 : 1'b1;
      end
   end

   assign hit    = exists_ff && !old_none && (rd_ff[old_buf] < fill_ff[old_buf]);
   assign rd_inc = rd_ff[old_buf] + CW'(1);
   assign avail  = (cfg.armed && exists_ff && !old_none) ?
                   (fill_ff[old_buf] - rd_ff[old_buf]) : '0;
   assign avail_ext = LXW'(avail);

   assign stat.hit    = (kind == KIND_RETRIEVE) && hit;
   assign stat.index  = wst_ff[old_buf] + 32'(rd_ff[old_buf]);
   assign stat.avail  = avail_ext[10:0];
   assign stat.exists = exists_ff;

   assign wr_buf  = wbuf;
   assign wr_addr = wfill[AW-1:0];
   assign wr_data = packet_data[WORD_BITS-1:0];
   assign rd_buf  = old_buf;
   assign rd_addr = rd_ff[old_buf][AW-1:0];

   always_comb begin
      lat_delay_in  = lat_delay_ff;
      lat_len_in    = lat_len_ff;
      lat_retrig_in = lat_retrig_ff;
      lat_period_in = lat_period_ff;
      lat_policy_in = lat_policy_ff;
      pc_in         = pc_ff;
      ph_in         = ph_ff;
      fill_in       = fill_ff;
      rd_in         = rd_ff;
      wst_in        = wst_ff;
      cur_in        = cur_ff;
      exists_in     = exists_ff;
      active_in     = active_ff;
      dd_in         = dd_ff;
      wr_en         = 1'b0;
      rd_en         = 1'b0;
      if (accept) begin
         case (kind)
            KIND_PACKET: begin
               if (cfg.armed && exists_ff && active_ff) begin
                  pc_in = pc_ff + 32'd1;
                  if (!delay_wait) begin
                     dd_in = 1'b1;
                     ph_in = ph_next;
                     if (in_window) begin
                        if (ph_zero) begin
                           cur_in        = wbuf;
                           fill_in[wbuf] = '0;
                           rd_in[wbuf]   = '0;
                           wst_in[wbuf]  = pc_ff;
                        end
                        if (room) begin
                           wr_en         = 1'b1;
                           fill_in[wbuf] = wfill + CW'(1);
                        end
                     end
                  end
               end
            end
            KIND_RETRIEVE: begin
               if (hit) begin
                  rd_en = 1'b1;
                  if (rd_inc >= lat_len_ff) begin
                     rd_in[old_buf]   = '0;
                     fill_in[old_buf] = '0;
                     wst_in[old_buf]  = 32'd0;
                  end else begin
                     rd_in[old_buf] = rd_inc;
                  end
               end
            end
            KIND_START: begin
               if (cfg.armed && !(exists_ff && lat_policy_ff == POLICY_BLOCK)) begin
                  fill_in       = '{default: '0};
                  rd_in         = '{default: '0};
                  wst_in        = '{default: 32'd0};
                  cur_in        = 1'b0;
                  lat_delay_in  = cfg.trigger_delay;
                  lat_len_in    = len_new;
                  lat_retrig_in = cfg.retrigger_enable;
                  lat_period_in = cfg.retrigger_period;
                  lat_policy_in = cfg.end_policy;
                  pc_in         = 32'd0;
                  ph_in         = 32'd0;
                  dd_in         = 1'b0;
                  exists_in     = 1'b1;
                  active_in     = 1'b1;
               end
            end
            KIND_STOP: begin
               if (cfg.armed && exists_ff && active_ff) begin
                  active_in = 1'b0;
                  if (lat_policy_ff == POLICY_DISCARD) begin
                     fill_in   = '{default: '0};
                     rd_in     = '{default: '0};
                     wst_in    = '{default: 32'd0};
                     cur_in    = 1'b0;
                     exists_in = 1'b0;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lat_delay_ff  <= 32'd0;
         lat_len_ff    <= (BUFFER_DEPTH > 1) ? CW'(1) : CW'(BUFFER_DEPTH);
         lat_retrig_ff <= 1'b0;
         lat_period_ff <= 32'd1;
         lat_policy_ff <= POLICY_DISCARD;
         pc_ff         <= 32'd0;
         ph_ff         <= 32'd0;
         fill_ff       <= '{default: '0};
         rd_ff         <= '{default: '0};
         wst_ff        <= '{default: 32'd0};
         cur_ff        <= 1'b0;
         exists_ff     <= 1'b0;
         active_ff     <= 1'b0;
         dd_ff         <= 1'b0;
      end else begin
         lat_delay_ff  <= lat_delay_in;
         lat_len_ff    <= lat_len_in;
         lat_retrig_ff <= lat_retrig_in;
         lat_period_ff <= lat_period_in;
         lat_policy_ff <= lat_policy_in;
         pc_ff         <= pc_in;
         ph_ff         <= ph_in;
         fill_ff       <= fill_in;
         rd_ff         <= rd_in;
         wst_ff        <= wst_in;
         cur_ff        <= cur_in;
         exists_ff     <= exists_in;
         active_ff     <= active_in;
         dd_ff         <= dd_in;
      end
   end

   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      (fill_ff[0] <= lat_len_ff) && (fill_ff[1] <= lat_len_ff))
      else $error("Buffer fill count exceeds the window length.");

   a_read_behind_fill: assert property (@(posedge clock) disable iff (reset)
      (rd_ff[0] <= fill_ff[0]) && (rd_ff[1] <= fill_ff[1]))
      else $error("Read count passed the fill count.");

   a_empty_without_capture: assert property (@(posedge clock) disable iff (reset)
      !exists_ff |-> (fill_ff[0] == '0) && (fill_ff[1] == '0))
      else $error("Buffers hold data while no capture exists.");

   a_one_port_access: assert property (@(posedge clock) disable iff (reset)
      !(wr_en && rd_en))
      else $error("Memory written and read by the same transfer.");

endmodule

FILE: hdl/triggered_window_pingpong_capture.sv
// ----------------------------------------------------------------------------
// triggered_window_pingpong_capture
// Triggered snapshot capture of a packet stream into two ping-pong buffers.
// ----------------------------------------------------------------------------
// The req_chan channel carries items of four kinds: start, packet, retrieve
// and stop. Each transfer on req_chan produces exactly one transfer on
// rsp_chan, in order. A start latches the capture settings from the csr_
// registers, after the trigger delay a window of packets is written to the
// current buffer, and a retrieve returns the next word of the oldest filled
// buffer together with its packet index.
// One item is taken per cycle while rsp_chan does not stall. An item's result
// passes through the first stage, which holds the counter update and the
// memory access, whose read data is registered, and then through the result
// register before it appears on rsp_chan. A retrieve reads the store in the
// cycle of its transfer. A stalled rsp_chan holds its result; one more item
// is taken into the first stage behind it, and then req_chan.ready drops
// until the result register drains.
// Reset clears all counters and flags; the store is not cleared, since only
// words written since their buffer was last emptied can ever be read.
// ----------------------------------------------------------------------------
module triggered_window_pingpong_capture #(
   parameter int BUFFER_DEPTH = 1024,
   parameter int WORD_BITS    = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   twc_req_if.sink                     req_chan,
   twc_rsp_if.source                   rsp_chan,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [twc_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [31:0]                 csr_pwdata,
   output logic [31:0]                 csr_prdata,
   output logic                        csr_pready
);
   import twc_pkg::*;

   localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
   localparam int CW = $clog2(BUFFER_DEPTH + 1);

   cfg_type              cfg;
   stat_type             stat;
   logic                 accept;
   logic                 p1_move;
   logic                 wr_en;
   logic                 wr_buf;
   logic [AW-1:0]        wr_addr;
   logic [WORD_BITS-1:0] wr_data;
   logic                 rd_en;
   logic                 rd_buf;
   logic [AW-1:0]        rd_addr;
   logic [WORD_BITS-1:0] rd_data;

   logic        p1_valid_ff, p1_valid_in;
   logic        p1_hit_ff;
   logic [31:0] p1_index_ff;
   logic        out_valid_ff, out_valid_in;
   logic        out_hit_ff;
   logic [63:0] out_data_ff;
   logic [31:0] out_index_ff;
   logic [10:0] out_avail_ff;
   logic        out_exists_ff;

   twc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   twc_ctrl #(
      .BUFFER_DEPTH (BUFFER_DEPTH),
      .WORD_BITS    (WORD_BITS),
      .AW           (AW),
      .CW           (CW)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .accept      (accept),
      .kind        (req_chan.kind),
      .packet_data (req_chan.packet_data),
      .wr_en       (wr_en),
      .wr_buf      (wr_buf),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .rd_en       (rd_en),
      .rd_buf      (rd_buf),
      .rd_addr     (rd_addr),
      .stat        (stat)
   );

   twc_store #(
      .BUFFER_DEPTH (BUFFER_DEPTH),
      .WORD_BITS    (WORD_BITS),
      .AW           (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_buf  (wr_buf),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_buf  (rd_buf),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign p1_move        = p1_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !p1_valid_ff || p1_move;
   assign accept         = req_chan.valid && req_chan.ready;

   assign p1_valid_in  = accept ? 1'b1 : (p1_move ? 1'b0 : p1_valid_ff);
   assign out_valid_in = p1_move ? 1'b1 : (rsp_chan.ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff  <= p1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         p1_hit_ff   <= stat.hit;
         p1_index_ff <= stat.index;
      end
      if (p1_move) begin
         out_hit_ff    <= p1_hit_ff;
         out_data_ff   <= p1_hit_ff ? 64'(rd_data) : 64'd0;
         out_index_ff  <= p1_hit_ff ? p1_index_ff : 32'd0;
         out_avail_ff  <= stat.avail;
         out_exists_ff <= stat.exists;
      end
   end

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.read_valid     = out_hit_ff;
   assign rsp_chan.read_data      = out_data_ff;
   assign rsp_chan.read_index     = out_index_ff;
   assign rsp_chan.retrievable    = out_avail_ff;
   assign rsp_chan.capture_exists = out_exists_ff;

endmodule

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the triggered ping-pong window capture block.
// ----------------------------------------------------------------------------
// Items are queued by the stimulus process and sent by a clocked driver. Every
// accepted transfer is run through a cycle-free model of the capture logic,
// and the outcome is queued. The monitor compares each result transfer with
// the oldest queued outcome, field by field. The capture settings are changed
// through the APB port between phases, only when no result is outstanding.
// Both channels idle in random bursts, except in the final phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
   import twc_pkg::*;

   localparam int BUFFER_DEPTH = 1024;
   localparam int CYCLE_LIMIT  = 400000;

   typedef struct packed {
      kind_type    kind;
      logic [63:0] data;
   } capture_item_type;

   typedef struct packed {
      logic        read_valid;
      logic [63:0] read_data;
      logic [31:0] read_index;
      logic [10:0] retrievable;
      logic        capture_exists;
   } readout_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [CSR_AW-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   twc_req_if req_chan();
   twc_rsp_if rsp_chan();

   triggered_window_pingpong_capture i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   capture_item_type item_q[$];
   readout_type      readout_q[$];
   int               mismatch_count = 0;
   int               cycle_count = 0;
   int               src_gap = 0;
   int               sink_gap = 0;
   bit               steady = 1'b0;

   // Register copies and the settings latched at the last accepted start.
   logic        cfg_armed = 1'b0;
   logic [31:0] cfg_delay = '0;
   logic [10:0] cfg_len = 11'd1;
   logic        cfg_retrig = 1'b0;
   logic [31:0] cfg_period = 32'd1;
   logic [1:0]  cfg_policy = POLICY_DISCARD;
   logic [31:0] run_delay = '0;
   logic [10:0] run_len = 11'd1;
   logic        run_retrig = 1'b0;
   logic [31:0] run_period = 32'd1;
   logic [1:0]  run_policy = POLICY_DISCARD;

   logic [31:0] pkt_count = '0;
   logic [31:0] phase = '0;
   logic [63:0] snap_mem [2][BUFFER_DEPTH];
   logic [10:0] fill [2] = '{default: '0};
   logic [10:0] taken [2] = '{default: '0};
   logic [31:0] win_start [2] = '{default: '0};
   logic        cur_buf = 1'b0;
   logic        exists = 1'b0;
   logic        active = 1'b0;
   logic        delay_passed = 1'b0;

   function automatic void clear_snaps();
      for (int b = 0; b < 2; b++) begin
         fill[b] = '0;
         taken[b] = '0;
         win_start[b] = '0;
      end
      cur_buf = 1'b0;
   endfunction

   // Returns 2 when both buffers are empty.
   function automatic logic [1:0] oldest_snap();
      if (fill[0] == 0) return (fill[1] == 0) ? 2'd2 : 2'd1;
      if (fill[1] == 0) return 2'd0;
      return (win_start[0] <= win_start[1]) ? 2'd0 : 2'd1;
   endfunction

   function automatic void put_word(input logic [63:0] d, input logic [31:0] pos);
      logic c;
      c = cur_buf;
      if (pos == 0) begin
         if (fill[c] != 0 && taken[c] != 0) c = ~c;
         cur_buf = c;
         fill[c] = '0;
         taken[c] = '0;
         win_start[c] = pkt_count;
      end
      if (fill[c] >= run_len || fill[c] >= BUFFER_DEPTH) return;
      snap_mem[c][fill[c]] = d;
      fill[c] = fill[c] + 1'b1;
   endfunction

   function automatic void take_packet(input logic [63:0] d);
      if (!delay_passed) begin
         if (pkt_count < run_delay) begin
            pkt_count = pkt_count + 1;
            return;
         end
         delay_passed = 1'b1;
         phase = '0;
      end
      if (phase < run_len) put_word(d, phase);
      if (run_retrig) begin
         phase = phase + 1;
         if (phase >= run_period) phase = '0;
      end else if (phase < run_len) begin
         phase = phase + 1;
      end
      pkt_count = pkt_count + 1;
   endfunction

   function automatic readout_type capture_advance(input kind_type k, input logic [63:0] d);
      readout_type r;
      logic [1:0]  w;
      logic        b;
      r = '0;
      case (k)
         KIND_PACKET: begin
            if (cfg_armed && exists && active) take_packet(d);
         end
         KIND_RETRIEVE: begin
            w = oldest_snap();
            b = w[0];
            if (exists && w != 2'd2 && taken[b] < fill[b]) begin
               r.read_valid = 1'b1;
               r.read_data = snap_mem[b][taken[b]];
               r.read_index = win_start[b] + taken[b];
               taken[b] = taken[b] + 1'b1;
               if (taken[b] >= run_len) begin
                  taken[b] = '0;
                  fill[b] = '0;
                  win_start[b] = '0;
               end
            end
         end
         KIND_START: begin
            if (cfg_armed && !(exists && run_policy == POLICY_BLOCK)) begin
               clear_snaps();
               run_delay = cfg_delay;
               run_len = (cfg_len > 11'd1024) ? 11'd1024 : cfg_len;
               run_retrig = cfg_retrig;
               run_period = cfg_period;
               run_policy = cfg_policy;
               pkt_count = '0;
               phase = '0;
               delay_passed = 1'b0;
               exists = 1'b1;
               active = 1'b1;
            end
         end
         default: begin
            if (cfg_armed && exists && active) begin
               active = 1'b0;
               if (run_policy == POLICY_DISCARD) begin
                  clear_snaps();
                  exists = 1'b0;
               end
            end
         end
      endcase
      if (cfg_armed && exists) begin
         w = oldest_snap();
         b = w[0];
         if (w != 2'd2 && fill[b] > taken[b]) r.retrievable = fill[b] - taken[b];
      end
      r.capture_exists = exists;
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Driver: predicts on each accepted transfer, then presents the next item.
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready)
            readout_q.push_back(capture_advance(kind_type'(req_chan.kind),
                                                req_chan.packet_data));
         if (!req_chan.valid || req_chan.ready) begin
            if (src_gap != 0) begin
               src_gap <= src_gap - 1;
               req_chan.valid <= 1'b0;
            end else if (item_q.size() != 0) begin
               if (!steady && $urandom_range(0, 5) == 0) begin
                  src_gap <= $urandom_range(0, 10);
                  req_chan.valid <= 1'b0;
               end else begin
                  req_chan.valid <= 1'b1;
                  req_chan.kind <= item_q[0].kind;
                  req_chan.packet_data <= item_q[0].data;
                  void'(item_q.pop_front());
               end
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each result transfer and throttles the result channel.
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (readout_q.size() == 0) begin
               $error("result transfer with no expectation pending");
               mismatch_count++;
            end else begin
               check_field("read_valid", readout_q[0].read_valid, rsp_chan.read_valid);
               check_field("read_data", readout_q[0].read_data, rsp_chan.read_data);
               check_field("read_index", readout_q[0].read_index, rsp_chan.read_index);
               check_field("retrievable", readout_q[0].retrievable, rsp_chan.retrievable);
               check_field("capture_exists", readout_q[0].capture_exists,
                           rsp_chan.capture_exists);
               void'(readout_q.pop_front());
            end
         end
         if (sink_gap != 0) begin
            sink_gap <= sink_gap - 1;
            rsp_chan.ready <= 1'b0;
         end else if (!steady && $urandom_range(0, 7) == 0) begin
            sink_gap <= $urandom_range(0, 10);
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   function automatic logic [63:0] rand_word();
      case ($urandom_range(0, 15))
         0: return '1;
         1: return '0;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic void queue_item(input kind_type k, input logic [63:0] d);
      capture_item_type it;
      it.kind = k;
      it.data = d;
      item_q.push_back(it);
   endfunction

   // Mostly start/traffic/drain/stop sequences, with some stray items between.
   function automatic void queue_episodes(input int n_items);
      int target;
      int len;
      int roll;
      target = item_q.size() + n_items;
      while (item_q.size() < target) begin
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 6))
               queue_item(kind_type'($urandom_range(0, 3)), rand_word());
         end
         queue_item(KIND_START, rand_word());
         len = $urandom_range(4, 60);
         for (int i = 0; i < len; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < 55) queue_item(KIND_PACKET, rand_word());
            else if (roll < 93) queue_item(KIND_RETRIEVE, rand_word());
            else if (roll < 96) queue_item(KIND_START, rand_word());
            else queue_item(KIND_STOP, rand_word());
         end
         repeat ($urandom_range(0, 8)) queue_item(KIND_RETRIEVE, rand_word());
         queue_item(KIND_STOP, rand_word());
      end
   endfunction

   task automatic wait_drained();
      do @(negedge clock);
      while (item_q.size() != 0 || req_chan.valid || readout_q.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic csr_write(input reg_index_type idx, input logic [31:0] v);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= v;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock);
      while (csr_pready !== 1'b1);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         REG_ARMED:            cfg_armed = v[0];
         REG_TRIGGER_DELAY:    cfg_delay = v;
         REG_WINDOW_LENGTH:    cfg_len = v[10:0];
         REG_RETRIGGER_ENABLE: cfg_retrig = v[0];
         REG_RETRIGGER_PERIOD: cfg_period = v;
         default:              cfg_policy = v[1:0];
      endcase
   endtask

   task automatic apply_settings(input logic armed, input logic [31:0] delay,
                                 input logic [10:0] len, input logic retrig,
                                 input logic [31:0] period, input logic [1:0] policy);
      wait_drained();
      csr_write(REG_ARMED, 32'(armed));
      csr_write(REG_TRIGGER_DELAY, delay);
      csr_write(REG_WINDOW_LENGTH, 32'(len));
      csr_write(REG_RETRIGGER_ENABLE, 32'(retrig));
      csr_write(REG_RETRIGGER_PERIOD, period);
      csr_write(REG_END_POLICY, 32'(policy));
   endtask

   initial begin
      req_chan.valid = 1'b0;
      req_chan.kind = KIND_PACKET;
      req_chan.packet_data = '0;
      rsp_chan.ready = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Nothing is armed yet, so every item is ignored.
      queue_item(KIND_START, '0);
      queue_item(KIND_PACKET, '1);
      queue_item(KIND_RETRIEVE, '0);
      queue_item(KIND_STOP, '0);

      apply_settings(1'b1, 32'd2, 11'd3, 1'b1, 32'd5, POLICY_HOLD);
      queue_item(KIND_RETRIEVE, '0);
      queue_item(KIND_STOP, '0);
      queue_item(KIND_PACKET, '1);
      queue_item(KIND_START, '0);
      queue_item(KIND_PACKET, '1);
      queue_item(KIND_PACKET, '0);
      queue_item(KIND_PACKET, '1);
      queue_item(KIND_PACKET, '0);
      queue_item(KIND_PACKET, 64'h5555_5555_5555_5555);
      queue_item(KIND_PACKET, 64'hAAAA_AAAA_AAAA_AAAA);
      queue_item(KIND_PACKET, rand_word());
      queue_item(KIND_PACKET, rand_word());
      queue_item(KIND_PACKET, rand_word());
      repeat (4) queue_item(KIND_RETRIEVE, '0);
      queue_item(KIND_STOP, '0);
      queue_item(KIND_PACKET, '1);
      queue_item(KIND_START, '0);
      queue_item(KIND_RETRIEVE, '0);
      queue_item(KIND_STOP, '0);

      apply_settings(1'b1, 32'd0, 11'd1, 1'b0, 32'd1, POLICY_DISCARD);
      queue_episodes(40);
      apply_settings(1'b1, $urandom_range(0, 6), 11'($urandom_range(2, 8)), 1'b1,
                     $urandom_range(2, 12), POLICY_HOLD);
      queue_episodes(40);
      apply_settings(1'b1, 32'hFFFF_FFFF, 11'($urandom_range(1, 8)), 1'b1, 32'hFFFF_FFFF,
                     POLICY_DISCARD);
      queue_episodes(30);
      apply_settings(1'b1, $urandom_range(0, 5), 11'd0, 1'b1, 32'd0, 2'd3);
      queue_episodes(30);
      apply_settings(1'b1, $urandom_range(0, 3), 11'($urandom_range(1, 6)), 1'b1, 32'd0,
                     POLICY_HOLD);
      queue_episodes(30);
      apply_settings(1'b0, $urandom_range(0, 3), 11'($urandom_range(1, 6)), 1'b0, 32'd3,
                     POLICY_HOLD);
      queue_episodes(20);

      // A window longer than the buffer is cut to the buffer depth.
      apply_settings(1'b1, $urandom_range(0, 8), 11'd2047, 1'b0, $urandom_range(1, 40),
                     POLICY_HOLD);
      queue_item(KIND_START, '0);
      for (int i = 0; i < 1040; i++) begin
         queue_item(KIND_PACKET, rand_word());
         if (i % 64 == 63) queue_item(KIND_RETRIEVE, '0);
      end
      repeat (30) queue_item(KIND_RETRIEVE, '0);
      queue_item(KIND_STOP, '0);

      for (int p = 0; p < 3; p++) begin
         apply_settings(1'b1, $urandom_range(0, 10), 11'($urandom_range(1, 16)),
                        1'($urandom_range(0, 1)), $urandom_range(1, 24),
                        2'($urandom_range(0, 3)));
         queue_episodes(30);
      end
      apply_settings(1'b1, $urandom_range(0, 4), 11'($urandom_range(4, 12)), 1'b1,
                     $urandom_range(1, 3), POLICY_BLOCK);
      queue_episodes(30);

      apply_settings(1'b1, $urandom_range(0, 6), 11'($urandom_range(1, 10)), 1'b1,
                     $urandom_range(1, 16), POLICY_DISCARD);
      steady = 1'b1;
      queue_episodes(40);

      wait_drained();
      repeat (10) @(negedge clock);
      if (mismatch_count == 0 && readout_q.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

FILE: files.f
hdl/twc_pkg.sv
hdl/twc_req_if.sv
hdl/twc_rsp_if.sv
hdl/twc_csr.sv
hdl/twc_store.sv
hdl/twc_ctrl.sv
hdl/triggered_window_pingpong_capture.sv
bench/tb_top.sv
